[hdl/accumulator_mod_p_repacker_core_assert.svh]
// Assertion macros used by the repacker checker file.
`ifndef ACCUMULATOR_MOD_P_REPACKER_CORE_ASSERT_SVH
`define ACCUMULATOR_MOD_P_REPACKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AMPR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("repacker check failed");

// Implication with a delay given by n, disabled while reset is asserted.
`define AMPR_ASSERT_DLY(lbl, clk, rst_n, ante, n, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
		else $error("repacker latency check failed");

`endif

[hdl/ampr_pkg.sv]
// Shared types and constants of the accumulator repacker.
package ampr_pkg;

	localparam int unsigned RECIP_W = 48;
	localparam int unsigned RECIP_HALF = RECIP_W / 2;
	localparam int unsigned LANE_W = 16;
	localparam int unsigned LANE10_W = 10;
	localparam int unsigned PROD_W = LANE_W + RECIP_HALF;

	// Configuration register indexes.
	localparam logic [1:0] REG_FORM = 2'd0;
	localparam logic [1:0] REG_MODULUS = 2'd1;
	localparam logic [1:0] REG_RECIP = 2'd2;

	localparam logic [2:0] FORM_RESET = 3'd1;
	localparam logic [7:0] MODULUS_RESET = 8'd5;
	localparam logic [RECIP_W-1:0] RECIP_RESET = 48'd56294995342132;

	typedef enum logic [2:0] {
		FORM_COPY = 3'd0,
		FORM_LANE16 = 3'd1,
		FORM_LANE10 = 3'd2,
		FORM_DIGIT2 = 3'd3,
		FORM_DIGIT3 = 3'd4
	} form_t;

	typedef struct packed {
		form_t form;
		logic [1:0] count;
	} ctrl_t;

endpackage

[hdl/ampr_lane.sv]
// Three-stage Barrett reduction of one lane, low byte of the remainder only.
module ampr_lane (
	input logic clk,
	input logic [ampr_pkg::LANE_W-1:0] x,
	input logic [ampr_pkg::RECIP_W-1:0] recip,
	input logic [7:0] modulus,
	output logic [7:0] rem
);

	logic [ampr_pkg::PROD_W-1:0] pl_s1;
	logic [ampr_pkg::PROD_W-1:0] ph_s1;
	logic [7:0] raw_s1;
	logic [7:0] q_s2;
	logic [7:0] raw_s2;
	logic [7:0] rem_s3;
	logic [ampr_pkg::PROD_W-1:0] psum;
	logic [7:0] qp;

	// The product is split into two 16x24 halves; bits 55:48 of the full
	// product are the low byte of the quotient.
	assign psum = ph_s1 + {{ampr_pkg::RECIP_HALF{1'b0}},
		pl_s1[ampr_pkg::PROD_W-1:ampr_pkg::RECIP_HALF]};
	assign qp = q_s2 * modulus;

	always_ff @(posedge clk) begin
		pl_s1 <= ampr_pkg::PROD_W'(x) *
			ampr_pkg::PROD_W'(recip[ampr_pkg::RECIP_HALF-1:0]);
		ph_s1 <= ampr_pkg::PROD_W'(x) *
			ampr_pkg::PROD_W'(recip[ampr_pkg::RECIP_W-1:ampr_pkg::RECIP_HALF]);
		raw_s1 <= x[7:0];
		q_s2 <= psum[ampr_pkg::RECIP_HALF+7:ampr_pkg::RECIP_HALF];
		raw_s2 <= raw_s1;
		rem_s3 <= raw_s2 - qp;
	end

	assign rem = rem_s3;

endmodule

[hdl/accumulator_mod_p_repacker_core.sv]
// Top level of the accumulator repacker: lane select, Barrett lanes, digit combine.
//
// Channel   Direction  Handshake            Payload
// input     in         start (busy low)     acc_word, lane_count
// result    out        done, one cycle      byte_zero, byte_one, byte_two, byte_count
// config    in         cfg_wr_en            cfg_idx, cfg_data
//
// One transaction per cycle; every accepted transaction gives its result through the
// two-part 16x48 quotient product, the digit products and the output registers.
// busy is always low. Reset clears the valid pipeline and loads the register
// defaults. The receiver cannot stall, so the pipeline never holds.
module accumulator_mod_p_repacker_core (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [31:0] acc_word,
	input logic [1:0] lane_count,
	input logic cfg_wr_en,
	input logic [1:0] cfg_idx,
	input logic [ampr_pkg::RECIP_W-1:0] cfg_data,
	output logic done,
	output logic [7:0] byte_zero,
	output logic [7:0] byte_one,
	output logic [7:0] byte_two,
	output logic [1:0] byte_count
);

	logic [2:0] form_q;
	logic [7:0] modulus_q;
	logic [ampr_pkg::RECIP_W-1:0] recip_q;
	logic [7:0] pp_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	ampr_pkg::ctrl_t ctrl_in, ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4;
	logic [ampr_pkg::LANE_W-1:0] x0, x1, x2;
	logic [7:0] rem0, rem1, rem2;
	logic [7:0] raw_s1, raw_s2, raw_s3;
	logic [7:0] r0_s4, r1_s4, r2_s4, raw_s4, zp_s4, wpp_s4;
	logic [7:0] b0_s5, b1_s5, b2_s5;
	logic [1:0] cnt_s5;
	logic [7:0] b0_nx, b1_nx, b2_nx;
	logic [1:0] cnt_nx;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			form_q <= ampr_pkg::FORM_RESET;
			modulus_q <= ampr_pkg::MODULUS_RESET;
			recip_q <= ampr_pkg::RECIP_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_idx)
				ampr_pkg::REG_FORM: form_q <= cfg_data[2:0];
				ampr_pkg::REG_MODULUS: modulus_q <= cfg_data[7:0];
				ampr_pkg::REG_RECIP: recip_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// p*p for the three-digit form, settled long before a transaction needs it.
	always_ff @(posedge clk) begin
		pp_q <= modulus_q * modulus_q;
	end

	always_comb begin
		ctrl_in.count = 2'd1;
		x0 = {8'd0, acc_word[7:0]};
		x1 = '0;
		x2 = '0;
		case (form_q)
			ampr_pkg::FORM_LANE16: begin
				ctrl_in.form = ampr_pkg::FORM_LANE16;
				x0 = acc_word[15:0];
			end
			ampr_pkg::FORM_LANE10: begin
				ctrl_in.form = ampr_pkg::FORM_LANE10;
				ctrl_in.count = (lane_count == 2'd0) ? 2'd3 : lane_count;
				x0 = ampr_pkg::LANE_W'(acc_word[9:0]);
				x1 = ampr_pkg::LANE_W'(acc_word[19:10]);
				x2 = ampr_pkg::LANE_W'(acc_word[29:20]);
			end
			ampr_pkg::FORM_DIGIT2: begin
				ctrl_in.form = ampr_pkg::FORM_DIGIT2;
				x1 = {8'd0, acc_word[15:8]};
			end
			ampr_pkg::FORM_DIGIT3: begin
				ctrl_in.form = ampr_pkg::FORM_DIGIT3;
				x1 = {8'd0, acc_word[15:8]};
				x2 = {8'd0, acc_word[23:16]};
			end
			default: ctrl_in.form = ampr_pkg::FORM_COPY;
		endcase
	end

	ampr_lane u_lane0 (.clk(clk), .x(x0), .recip(recip_q), .modulus(modulus_q),
		.rem(rem0));
	ampr_lane u_lane1 (.clk(clk), .x(x1), .recip(recip_q), .modulus(modulus_q),
		.rem(rem1));
	ampr_lane u_lane2 (.clk(clk), .x(x2), .recip(recip_q), .modulus(modulus_q),
		.rem(rem2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		ctrl_s1 <= ctrl_in;
		ctrl_s2 <= ctrl_s1;
		ctrl_s3 <= ctrl_s2;
		ctrl_s4 <= ctrl_s3;
		raw_s1 <= acc_word[7:0];
		raw_s2 <= raw_s1;
		raw_s3 <= raw_s2;
		r0_s4 <= rem0;
		r1_s4 <= rem1;
		r2_s4 <= rem2;
		raw_s4 <= raw_s3;
		zp_s4 <= rem1 * modulus_q;
		wpp_s4 <= rem2 * pp_q;
		b0_s5 <= b0_nx;
		b1_s5 <= b1_nx;
		b2_s5 <= b2_nx;
		cnt_s5 <= cnt_nx;
	end

	// Unused lanes of the 10-bit form read as zero.
	always_comb begin
		b1_nx = '0;
		b2_nx = '0;
		cnt_nx = ctrl_s4.count;
		case (ctrl_s4.form)
			ampr_pkg::FORM_LANE16: b0_nx = r0_s4;
			ampr_pkg::FORM_LANE10: begin
				b0_nx = r0_s4;
				if (ctrl_s4.count != 2'd1) b1_nx = r1_s4;
				if (ctrl_s4.count == 2'd3) b2_nx = r2_s4;
			end
			ampr_pkg::FORM_DIGIT2: b0_nx = r0_s4 + zp_s4;
			ampr_pkg::FORM_DIGIT3: b0_nx = r0_s4 + zp_s4 + wpp_s4;
			default: b0_nx = raw_s4;
		endcase
	end

	assign done = v_s5;
	assign byte_zero = b0_s5;
	assign byte_one = b1_s5;
	assign byte_two = b2_s5;
	assign byte_count = cnt_s5;

endmodule

[hdl/ampr_checker.sv]
// Port-level checker for the accumulator repacker, bound to the top level.
`include "accumulator_mod_p_repacker_core_assert.svh"

module ampr_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic [7:0] byte_one,
	input logic [7:0] byte_two,
	input logic [1:0] byte_count
);

	`AMPR_ASSERT_DLY(a_result_follows, clk, arst_n, start && !busy, 5, done)
	`AMPR_ASSERT_DLY(a_no_spurious, clk, arst_n, !(start && !busy), 5, !done)
	`AMPR_ASSERT_IMP(a_count_nonzero, clk, arst_n, done, byte_count != 2'd0)
	`AMPR_ASSERT_IMP(a_single_byte, clk, arst_n, done && byte_count == 2'd1,
		byte_one == 8'd0 && byte_two == 8'd0)

endmodule

bind accumulator_mod_p_repacker_core ampr_checker u_ampr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.byte_one(byte_one),
	.byte_two(byte_two),
	.byte_count(byte_count)
);
